/* sv/set_assoc_cache_controller_defines.svh */
// Assertion macros for the cache controller RTL, included by its back part.
// Included by files that carry concurrent checks; needs no other file.
`ifndef SET_ASSOC_CACHE_CONTROLLER_DEFINES_SVH
`define SET_ASSOC_CACHE_CONTROLLER_DEFINES_SVH
`ifndef SYNTHESIS
`define SACC_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define SACC_ASSERT_NR(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SACC_ASSERT(lbl, clk, rst, prop, msg)
`define SACC_ASSERT_NR(lbl, clk, prop, msg)
`endif
`endif

/* sv/sacc_pkg.sv */
// Types, constants and helpers for the set-associative cache controller.
// Used by the top, front and back modules; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package sacc_pkg;
  localparam int ADDR_W    = 32;
  localparam int TAG_W     = 32;
  localparam int CNT_W     = 32;
  localparam int NUM_LANES = 8;
  localparam int LANE_W    = 3;
  localparam int INDEX_W   = 10;
  localparam int ROW_W     = INDEX_W - LANE_W;
  localparam int NUM_ROWS  = 1 << ROW_W;
  localparam int FLUSH_W   = INDEX_W + 1;
  localparam int NUM_CNT   = 6;

  localparam logic [ADDR_W-1:0] ADDR_ONE = 32'd1;
  localparam logic [15:0] LFSR_MASK = 16'hB400;
  localparam logic [15:0] LFSR_SEED = 16'h0001;

  localparam logic [1:0] MODE_WRITE  = 2'd1;
  localparam logic [1:0] MODE_FINISH = 2'd2;

  localparam logic [2:0] CFG_WRITE_BACK = 3'd0;
  localparam logic [2:0] CFG_RANDOM     = 3'd1;
  localparam logic [2:0] CFG_OFFSET     = 3'd2;
  localparam logic [2:0] CFG_SETS       = 3'd3;
  localparam logic [2:0] CFG_WAYS       = 3'd4;

  localparam int ST_RD    = 0;
  localparam int ST_WR    = 1;
  localparam int ST_RDHIT = 2;
  localparam int ST_WRHIT = 3;
  localparam int ST_MRD   = 4;
  localparam int ST_MWR   = 5;

  typedef enum logic [1:0] {
    OP_READ   = 2'd0,
    OP_WRITE  = 2'd1,
    OP_FINISH = 2'd2
  } op_t;

  typedef struct packed {
    logic       write_back;
    logic       random_replace;
    logic [4:0] offset_bits;
    logic [3:0] set_bits;
    logic [1:0] way_bits;
  } cfg_t;

  typedef struct packed {
    op_t               op;
    logic [ROW_W-1:0]  row;
    logic [LANE_W-1:0] lane;
    logic [TAG_W-1:0]  tag;
  } item_t;

  typedef struct packed {
    logic [TAG_W-1:0] tag;
    logic             valid;
    logic             dirty;
    logic [CNT_W-1:0] last_use;
  } line_t;

  typedef line_t [NUM_LANES-1:0] row_t;

  typedef struct packed {
    logic                          hit;
    logic                          mem_read;
    logic                          mem_write;
    logic [NUM_CNT-1:0][CNT_W-1:0] counts;
  } res_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    sat_inc = (v == '1) ? v : v + 32'd1;
  endfunction
endpackage
`default_nettype wire

/* sv/set_assoc_cache_controller.sv */
// Set-associative cache controller: the back part reads the row of an access, compares the
// tags and chooses a victim, then writes the row back. It takes a new access only after the
// last one has written its row and placed its result in the result queue; a full result
// queue holds it. In write-back mode a finish item sweeps all 128 rows, reading and writing
// each back; otherwise it goes straight to its report. After reset a clearing pass over all
// 128 rows holds full high; configuration writes go on.
`timescale 1ns / 1ps
`default_nettype none
module set_assoc_cache_controller (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  output logic             full,
  input  wire logic [1:0]  mode,
  input  wire logic [31:0] address,
  output logic             empty,
  input  wire logic        pop,
  output logic             hit,
  output logic             mem_read,
  output logic             mem_write,
  output logic [31:0]      read_count,
  output logic [31:0]      write_count,
  output logic [31:0]      read_hit_count,
  output logic [31:0]      write_hit_count,
  output logic [31:0]      mem_read_count,
  output logic [31:0]      mem_write_count,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [4:0]  cfg_data
);
  sacc_pkg::cfg_t  cfg;
  sacc_pkg::item_t q_item;
  sacc_pkg::res_t  res;
  sacc_pkg::res_t  res_out;
  logic            q_valid;
  logic            q_pop;
  logic            clearing;
  logic            res_push;
  logic            res_full;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.write_back     <= 1'b0;
      cfg.random_replace <= 1'b0;
      cfg.offset_bits    <= 5'd4;
      cfg.set_bits       <= 4'd7;
      cfg.way_bits       <= 2'd2;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        sacc_pkg::CFG_WRITE_BACK: cfg.write_back     <= cfg_data[0];
        sacc_pkg::CFG_RANDOM:     cfg.random_replace <= cfg_data[0];
        sacc_pkg::CFG_OFFSET:     cfg.offset_bits    <= cfg_data;
        sacc_pkg::CFG_SETS:       cfg.set_bits       <= cfg_data[3:0];
        sacc_pkg::CFG_WAYS:       cfg.way_bits       <= cfg_data[1:0];
        default: begin
        end
      endcase
    end
  end

  sacc_front u_front (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .hold   (clearing),
    .push   (push),
    .full   (full),
    .mode   (mode),
    .address(address),
    .q_valid(q_valid),
    .q_item (q_item),
    .q_pop  (q_pop)
  );

  sacc_back u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_pop   (q_pop),
    .clearing(clearing),
    .res_push(res_push),
    .res     (res),
    .res_full(res_full)
  );

  sacc_fifo #(
    .WIDTH($bits(sacc_pkg::res_t)),
    .DEPTH(2)
  ) u_results (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (res_push),
    .wr_data(res),
    .full   (res_full),
    .rd_en  (pop && !empty),
    .rd_data(res_out),
    .empty  (empty)
  );

  assign hit             = res_out.hit;
  assign mem_read        = res_out.mem_read;
  assign mem_write       = res_out.mem_write;
  assign read_count      = res_out.counts[sacc_pkg::ST_RD];
  assign write_count     = res_out.counts[sacc_pkg::ST_WR];
  assign read_hit_count  = res_out.counts[sacc_pkg::ST_RDHIT];
  assign write_hit_count = res_out.counts[sacc_pkg::ST_WRHIT];
  assign mem_read_count  = res_out.counts[sacc_pkg::ST_MRD];
  assign mem_write_count = res_out.counts[sacc_pkg::ST_MWR];
endmodule
`default_nettype wire

/* sv/sacc_ram.sv */
// Generic single-port-write, single-port-read RAM with a registered read.
// Stand-alone; used for the line store of the cache controller.
`timescale 1ns / 1ps
`default_nettype none
module sacc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end
endmodule
`default_nettype wire

/* sv/sacc_fifo.sv */
// Small synchronous queue; DEPTH must be a power of two, at least two.
// Stand-alone; used between the front and back parts and on the result side.
`timescale 1ns / 1ps
`default_nettype none
module sacc_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             wr_en,
  input  wire logic [WIDTH-1:0] wr_data,
  output logic                  full,
  input  wire logic             rd_en,
  output logic      [WIDTH-1:0] rd_data,
  output logic                  empty
);
  localparam int PW = $clog2(DEPTH);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [PW:0]      count;

  assign full    = (count == (PW+1)'(DEPTH));
  assign empty   = (count == '0);
  assign rd_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (wr_en && !rd_en) begin
        count <= count + 1'b1;
      end else if (rd_en && !wr_en) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots[wr_ptr] <= wr_data;
    end
  end
endmodule
`default_nettype wire

/* sv/sacc_front.sv */
// Front part: takes access items, splits the address into row, lane and tag,
// and queues them for the back part. Depends on sacc_pkg and sacc_fifo.
`timescale 1ns / 1ps
`default_nettype none
module sacc_front (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire sacc_pkg::cfg_t               cfg,
  input  wire logic                         hold,
  input  wire logic                         push,
  output logic                              full,
  input  wire logic [1:0]                   mode,
  input  wire logic [sacc_pkg::ADDR_W-1:0]  address,
  output logic                              q_valid,
  output sacc_pkg::item_t                   q_item,
  input  wire logic                         q_pop
);
  logic [3:0]                  set_room;
  logic [3:0]                  eff_set_bits;
  logic [sacc_pkg::ADDR_W-1:0] set_mask;
  logic [sacc_pkg::ADDR_W-1:0] set_idx;
  logic [sacc_pkg::ADDR_W-1:0] entry;
  logic [5:0]                  tag_shift;
  sacc_pkg::item_t             item;
  logic                        fifo_full;
  logic                        fifo_empty;
  logic                        accept;

  // Sets shrink so that sets times ways never exceeds the line store.
  assign set_room     = 4'd10 - {2'b00, cfg.way_bits};
  assign eff_set_bits = (cfg.set_bits < set_room) ? cfg.set_bits : set_room;
  assign set_mask     = (sacc_pkg::ADDR_ONE << eff_set_bits) - sacc_pkg::ADDR_ONE;
  assign set_idx      = (address >> cfg.offset_bits) & set_mask;
  assign entry        = set_idx << cfg.way_bits;
  assign tag_shift    = {1'b0, cfg.offset_bits} + {2'b00, cfg.set_bits};

  always_comb begin
    case (mode)
      sacc_pkg::MODE_FINISH: item.op = sacc_pkg::OP_FINISH;
      sacc_pkg::MODE_WRITE:  item.op = sacc_pkg::OP_WRITE;
      default:               item.op = sacc_pkg::OP_READ;
    endcase
    item.row  = entry[sacc_pkg::INDEX_W-1:sacc_pkg::LANE_W];
    item.lane = entry[sacc_pkg::LANE_W-1:0];
    item.tag  = sacc_pkg::TAG_W'(address >> tag_shift);
  end

  assign full    = fifo_full || hold;
  assign accept  = push && !full;
  assign q_valid = !fifo_empty;

  sacc_fifo #(
    .WIDTH($bits(sacc_pkg::item_t)),
    .DEPTH(2)
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (accept),
    .wr_data(item),
    .full   (fifo_full),
    .rd_en  (q_pop),
    .rd_data(q_item),
    .empty  (fifo_empty)
  );
endmodule
`default_nettype wire

/* sv/sacc_back.sv */
// Back part: line store, tag compare, victim choice, statistics and flush.
// Depends on sacc_pkg, sacc_ram and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "set_assoc_cache_controller_defines.svh"
module sacc_back (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire sacc_pkg::cfg_t  cfg,
  input  wire logic            q_valid,
  input  wire sacc_pkg::item_t q_item,
  output logic                 q_pop,
  output logic                 clearing,
  output logic                 res_push,
  output sacc_pkg::res_t       res,
  input  wire logic            res_full
);
  typedef enum logic [6:0] {
    S_INIT    = 7'b0000001,
    S_IDLE    = 7'b0000010,
    S_LOOK    = 7'b0000100,
    S_UPD     = 7'b0001000,
    S_FL_RD   = 7'b0010000,
    S_FL_WR   = 7'b0100000,
    S_FL_DONE = 7'b1000000
  } state_t;

  typedef struct packed {
    logic                          ok;
    logic [sacc_pkg::CNT_W-1:0]    val;
    logic [sacc_pkg::LANE_W-1:0]   idx;
  } cand_t;

  function automatic cand_t pick(input cand_t a, input cand_t b);
    pick = (a.ok && (!b.ok || a.val <= b.val)) ? a : b;
  endfunction

  state_t                                          state;
  state_t                                          state_next;
  logic [sacc_pkg::ROW_W-1:0]                      row;
  logic [sacc_pkg::CNT_W-1:0]                      acc_clock;
  logic [15:0]                                     lfsr;
  logic [sacc_pkg::NUM_CNT-1:0][sacc_pkg::CNT_W-1:0] cnt;
  logic [sacc_pkg::NUM_CNT-1:0][sacc_pkg::CNT_W-1:0] cnt_next;
  sacc_pkg::item_t                                 item_r;
  logic                                            hit_r;
  logic                                            alloc_r;
  logic                                            mwr_r;
  logic [sacc_pkg::LANE_W-1:0]                     hit_lane;
  logic [sacc_pkg::LANE_W-1:0]                     vict_lane;
  logic [sacc_pkg::FLUSH_W-1:0]                    flush_n;

  logic                             ram_rd_en;
  logic [sacc_pkg::ROW_W-1:0]       ram_rd_addr;
  logic                             ram_wr_en;
  logic [sacc_pkg::ROW_W-1:0]       ram_wr_addr;
  sacc_pkg::row_t                   ram_wr_data;
  sacc_pkg::row_t                   rd_row;
  sacc_pkg::row_t                   upd_row;
  sacc_pkg::row_t                   clean_row;

  logic                              is_wr;
  logic [3:0]                        ways4;
  logic [3:0]                        lane_end;
  logic [sacc_pkg::NUM_LANES-1:0]    in_set;
  logic [sacc_pkg::NUM_LANES-1:0]    hit_vec;
  logic [sacc_pkg::NUM_LANES-1:0]    empty_vec;
  logic [sacc_pkg::NUM_LANES-1:0]    vd_vec;
  logic [sacc_pkg::LANE_W-1:0]       first_hit;
  logic [sacc_pkg::LANE_W-1:0]       first_empty;
  logic [sacc_pkg::LANE_W-1:0]       rand_lane;
  logic [sacc_pkg::LANE_W-1:0]       vict_sel;
  logic [15:0]                       lfsr_nx;
  logic                              any_hit;
  logic                              any_empty;
  logic                              alloc;
  logic                              mwr;
  logic [3:0]                        dirty_cnt;
  logic [sacc_pkg::CNT_W:0]          flush_sum;
  cand_t                             leaf [sacc_pkg::NUM_LANES];
  cand_t                             lvl1 [4];
  cand_t                             lvl2 [2];
  cand_t                             lru;

  sacc_ram #(
    .WIDTH($bits(sacc_pkg::row_t)),
    .DEPTH(sacc_pkg::NUM_ROWS)
  ) u_lines (
    .clk    (clk),
    .wr_en  (ram_wr_en),
    .wr_addr(ram_wr_addr),
    .wr_data(ram_wr_data),
    .rd_en  (ram_rd_en),
    .rd_addr(ram_rd_addr),
    .rd_data(rd_row)
  );

  // Lookup on the row just read: hit, first empty way, oldest way, random way, allocation and memory write.
  always_comb begin
    is_wr    = (item_r.op == sacc_pkg::OP_WRITE);
    ways4    = 4'd1 << cfg.way_bits;
    lane_end = {1'b0, item_r.lane} + ways4;
    for (int l = 0; l < sacc_pkg::NUM_LANES; l++) begin
      in_set[l]    = (4'(l) >= {1'b0, item_r.lane}) && (4'(l) < lane_end);
      hit_vec[l]   = in_set[l] && rd_row[l].valid && (rd_row[l].tag == item_r.tag);
      empty_vec[l] = in_set[l] && !rd_row[l].valid;
      vd_vec[l]    = rd_row[l].valid && rd_row[l].dirty;
      leaf[l].ok   = in_set[l];
      leaf[l].val  = rd_row[l].last_use;
      leaf[l].idx  = sacc_pkg::LANE_W'(l);
    end
    first_hit   = '0;
    first_empty = '0;
    for (int l = sacc_pkg::NUM_LANES - 1; l >= 0; l--) begin
      if (hit_vec[l]) begin
        first_hit = sacc_pkg::LANE_W'(l);
      end
      if (empty_vec[l]) begin
        first_empty = sacc_pkg::LANE_W'(l);
      end
    end
    for (int i = 0; i < 4; i++) begin
      lvl1[i] = pick(leaf[2*i], leaf[2*i+1]);
    end
    for (int i = 0; i < 2; i++) begin
      lvl2[i] = pick(lvl1[2*i], lvl1[2*i+1]);
    end
    lru       = pick(lvl2[0], lvl2[1]);
    any_hit   = |hit_vec;
    any_empty = |empty_vec;
    lfsr_nx   = (lfsr >> 1) ^ (lfsr[0] ? sacc_pkg::LFSR_MASK : 16'h0000);
    rand_lane = item_r.lane + (lfsr_nx[sacc_pkg::LANE_W-1:0] & 3'(ways4 - 4'd1));
    if (any_empty) begin
      vict_sel = first_empty;
    end else if (cfg.random_replace) begin
      vict_sel = rand_lane;
    end else begin
      vict_sel = lru.idx;
    end
    alloc     = !any_hit && (!is_wr || cfg.write_back);
    mwr       = (is_wr && !cfg.write_back) ||
                (alloc && cfg.write_back && rd_row[vict_sel].dirty);
    dirty_cnt = 4'($countones(vd_vec));
  end

  // Row images written back to the store.
  always_comb begin
    upd_row   = rd_row;
    clean_row = rd_row;
    for (int l = 0; l < sacc_pkg::NUM_LANES; l++) begin
      clean_row[l].dirty = 1'b0;
    end
    if (hit_r) begin
      upd_row[hit_lane].last_use = acc_clock;
      if (is_wr && cfg.write_back) begin
        upd_row[hit_lane].dirty = 1'b1;
      end
    end
    if (alloc_r) begin
      upd_row[vict_lane].tag      = item_r.tag;
      upd_row[vict_lane].valid    = 1'b1;
      upd_row[vict_lane].dirty    = is_wr;
      upd_row[vict_lane].last_use = acc_clock;
    end
  end

  // Statistics as they stand after the item being reported.
  always_comb begin
    cnt_next  = cnt;
    flush_sum = {1'b0, cnt[sacc_pkg::ST_MWR]} + (sacc_pkg::CNT_W+1)'(flush_n);
    case (state)
      S_UPD: begin
        if (is_wr) begin
          cnt_next[sacc_pkg::ST_WR] = sacc_pkg::sat_inc(cnt[sacc_pkg::ST_WR]);
        end else begin
          cnt_next[sacc_pkg::ST_RD] = sacc_pkg::sat_inc(cnt[sacc_pkg::ST_RD]);
        end
        if (hit_r && is_wr) begin
          cnt_next[sacc_pkg::ST_WRHIT] = sacc_pkg::sat_inc(cnt[sacc_pkg::ST_WRHIT]);
        end
        if (hit_r && !is_wr) begin
          cnt_next[sacc_pkg::ST_RDHIT] = sacc_pkg::sat_inc(cnt[sacc_pkg::ST_RDHIT]);
        end
        if (alloc_r) begin
          cnt_next[sacc_pkg::ST_MRD] = sacc_pkg::sat_inc(cnt[sacc_pkg::ST_MRD]);
        end
        if (mwr_r) begin
          cnt_next[sacc_pkg::ST_MWR] = sacc_pkg::sat_inc(cnt[sacc_pkg::ST_MWR]);
        end
      end
      S_FL_DONE: begin
        cnt_next[sacc_pkg::ST_MWR] = flush_sum[sacc_pkg::CNT_W] ? '1 :
                                     flush_sum[sacc_pkg::CNT_W-1:0];
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    res.hit       = hit_r && (state == S_UPD);
    res.mem_read  = alloc_r && (state == S_UPD);
    res.mem_write = (state == S_UPD) ? mwr_r : (flush_n != '0);
    res.counts    = cnt_next;
  end

  assign res_push = ((state == S_UPD) || (state == S_FL_DONE)) && !res_full;
  assign q_pop    = (state == S_IDLE) && q_valid;
  assign clearing = (state == S_INIT);

  always_comb begin
    ram_rd_en   = 1'b0;
    ram_rd_addr = row;
    ram_wr_en   = 1'b0;
    ram_wr_addr = row;
    ram_wr_data = clean_row;
    state_next  = state;
    case (state)
      S_INIT: begin
        ram_wr_en   = 1'b1;
        ram_wr_data = '0;
        if (row == sacc_pkg::ROW_W'(sacc_pkg::NUM_ROWS - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        ram_rd_addr = q_item.row;
        if (q_valid) begin
          if (q_item.op != sacc_pkg::OP_FINISH) begin
            ram_rd_en  = 1'b1;
            state_next = S_LOOK;
          end else if (cfg.write_back) begin
            state_next = S_FL_RD;
          end else begin
            state_next = S_FL_DONE;
          end
        end
      end
      S_LOOK: begin
        state_next = S_UPD;
      end
      S_UPD: begin
        ram_wr_addr = item_r.row;
        ram_wr_data = upd_row;
        if (!res_full) begin
          ram_wr_en  = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_FL_RD: begin
        ram_rd_en  = 1'b1;
        state_next = S_FL_WR;
      end
      S_FL_WR: begin
        ram_wr_en = 1'b1;
        if (row == sacc_pkg::ROW_W'(sacc_pkg::NUM_ROWS - 1)) begin
          state_next = S_FL_DONE;
        end else begin
          state_next = S_FL_RD;
        end
      end
      S_FL_DONE: begin
        if (!res_full) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT;
      row       <= '0;
      acc_clock <= '0;
      lfsr      <= sacc_pkg::LFSR_SEED;
      cnt       <= '0;
    end else begin
      state <= state_next;
      cnt   <= res_push ? cnt_next : cnt;
      case (state)
        S_INIT, S_FL_WR: begin
          row <= row + 1'b1;
        end
        S_IDLE: begin
          row <= '0;
        end
        S_LOOK: begin
          acc_clock <= sacc_pkg::sat_inc(acc_clock);
          if (alloc && !any_empty && cfg.random_replace) begin
            lfsr <= lfsr_nx;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        item_r  <= q_item;
        flush_n <= '0;
      end
      S_LOOK: begin
        hit_r     <= any_hit;
        alloc_r   <= alloc;
        mwr_r     <= mwr;
        hit_lane  <= first_hit;
        vict_lane <= vict_sel;
      end
      S_FL_WR: begin
        flush_n <= flush_n + sacc_pkg::FLUSH_W'(dirty_cnt);
      end
      default: begin
      end
    endcase
  end

  `SACC_ASSERT_NR(a_reset_init, clk, rst |=> (state == S_INIT), "reset must start the clearing pass")
  `SACC_ASSERT(a_look_then_upd, clk, rst, (state == S_LOOK) |=> (state == S_UPD), "lookup not followed by update")
  `SACC_ASSERT(a_hit_no_alloc, clk, rst, (state == S_UPD) |-> !(hit_r && alloc_r), "hit and allocation together")
  `SACC_ASSERT(a_clock_moved, clk, rst, (state == S_UPD) |-> (acc_clock != '0), "access clock did not advance")
  `SACC_ASSERT(a_flush_bound, clk, rst, (state == S_FL_DONE) |-> (flush_n <= sacc_pkg::FLUSH_W'(1024)), "flush count exceeds line store")
endmodule
`default_nettype wire
